// ----- design/plp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plp_pkg: shared types and constants of the polyline path length unit
// Field widths, derived arithmetic widths, request structs and the state
// encoding of the back end.
// ----------------------------------------------------------------------------
package plp_pkg;

  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned TOTAL_BITS  = 40;

  // |dx|, |dy| fit COORD_BITS; the root of dx^2 + dy^2 needs one bit more.
  localparam int unsigned SQ_BITS     = 2 * COORD_BITS;
  localparam int unsigned ROOT_BITS   = COORD_BITS + 1;
  localparam int unsigned RAD_BITS    = 2 * ROOT_BITS;
  localparam int unsigned REM_BITS    = ROOT_BITS + 2;
  localparam int unsigned ACC_BITS    =
    ((ROOT_BITS > TOTAL_BITS) ? ROOT_BITS : TOTAL_BITS) + 1;
  localparam int unsigned CNT_BITS    = $clog2(ROOT_BITS);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last_point;
  } in_req_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] path_length;
    logic                  saturated;
  } out_req_t;

  // One classified point as handed from the front end to the back end.
  typedef struct packed {
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  has_seg;
    logic                  last;
  } seg_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_SUM,
    B_ROOT,
    B_ACCUM,
    B_EMIT
  } back_state_e;

endpackage
`default_nettype wire

// ----- design/plp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plp_front: point intake
// Accepts points, keeps the previous point of the path and turns each point
// into a segment command with the coordinate difference magnitudes.
// ----------------------------------------------------------------------------
module plp_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  plp_pkg::in_req_t           in_req_i,
  input  plp_pkg::queue_status_t     q_stat_i,
  output logic                       push_o,
  output plp_pkg::seg_cmd_t          push_cmd_o
);

  logic [plp_pkg::COORD_BITS-1:0] prev_x_q, prev_x_d;
  logic [plp_pkg::COORD_BITS-1:0] prev_y_q, prev_y_d;
  logic                           have_prev_q, have_prev_d;
  logic [plp_pkg::COORD_BITS:0]   diff_x, diff_y;
  logic [plp_pkg::COORD_BITS:0]   mag_x, mag_y;
  logic                           accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    diff_x = {in_req_i.x_coord[plp_pkg::COORD_BITS-1], in_req_i.x_coord}
           - {prev_x_q[plp_pkg::COORD_BITS-1], prev_x_q};
    diff_y = {in_req_i.y_coord[plp_pkg::COORD_BITS-1], in_req_i.y_coord}
           - {prev_y_q[plp_pkg::COORD_BITS-1], prev_y_q};
    mag_x  = diff_x[plp_pkg::COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
    mag_y  = diff_y[plp_pkg::COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

    push_o             = accept;
    push_cmd_o.dx      = mag_x[plp_pkg::COORD_BITS-1:0];
    push_cmd_o.dy      = mag_y[plp_pkg::COORD_BITS-1:0];
    push_cmd_o.has_seg = have_prev_q;
    push_cmd_o.last    = in_req_i.last_point;

    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    have_prev_d = have_prev_q;
    if (accept) begin
      prev_x_d    = in_req_i.x_coord;
      prev_y_d    = in_req_i.y_coord;
      // A last point closes the path: the next point starts a new one.
      have_prev_d = !in_req_i.last_point;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
    end else begin
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/plp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plp_queue: command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module plp_queue (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        push_i,
  input  plp_pkg::seg_cmd_t          push_cmd_i,
  input  wire                        pop_i,
  output plp_pkg::seg_cmd_t          pop_cmd_o,
  output plp_pkg::queue_status_t     stat_o
);

  plp_pkg::seg_cmd_t              entry_q [plp_pkg::QUEUE_DEPTH];
  logic [plp_pkg::QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [plp_pkg::QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [plp_pkg::QCNT_BITS-1:0]  count_q, count_d;
  logic                           do_push, do_pop;

  assign stat_o.full  = (count_q == plp_pkg::QCNT_BITS'(plp_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == plp_pkg::QPTR_BITS'(plp_pkg::QUEUE_DEPTH - 1))
               ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == plp_pkg::QPTR_BITS'(plp_pkg::QUEUE_DEPTH - 1))
               ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/plp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plp_back: segment length engine
// Squares the differences, takes the integer square root one bit per cycle,
// accumulates the saturating total and drives the result register.
// ----------------------------------------------------------------------------
module plp_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  plp_pkg::queue_status_t     q_stat_i,
  input  plp_pkg::seg_cmd_t          pop_cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output plp_pkg::out_req_t          out_req_o
);

  plp_pkg::back_state_e            state_q, state_d;
  logic [plp_pkg::TOTAL_BITS-1:0]  total_q, total_d;
  logic                            out_valid_q, out_valid_d;
  plp_pkg::out_req_t               out_q, out_d;

  plp_pkg::seg_cmd_t               cmd_q, cmd_d;
  logic [plp_pkg::SQ_BITS-1:0]     sq_x_q, sq_x_d, sq_y_q, sq_y_d;
  logic [plp_pkg::RAD_BITS-1:0]    rad_q, rad_d;
  logic [plp_pkg::REM_BITS-1:0]    rem_q, rem_d;
  logic [plp_pkg::ROOT_BITS-1:0]   root_q, root_d;
  logic [plp_pkg::CNT_BITS-1:0]    cnt_q, cnt_d;

  logic [plp_pkg::REM_BITS+1:0]    shifted, trial;
  logic [plp_pkg::ACC_BITS-1:0]    acc_sum;
  logic                            out_free;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd_d       = cmd_q;
    sq_x_d      = sq_x_q;
    sq_y_d      = sq_y_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;

    shifted = {rem_q, rad_q[plp_pkg::RAD_BITS-1 -: 2]};
    trial   = (plp_pkg::REM_BITS + 2)'({root_q, 2'b01});
    acc_sum = plp_pkg::ACC_BITS'(total_q) + plp_pkg::ACC_BITS'(root_q);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      plp_pkg::B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          cmd_d  = pop_cmd_i;
          root_d = '0;
          state_d = pop_cmd_i.has_seg ? plp_pkg::B_SQUARE : plp_pkg::B_ACCUM;
        end
      end
      plp_pkg::B_SQUARE: begin
        sq_x_d  = plp_pkg::SQ_BITS'(cmd_q.dx) * plp_pkg::SQ_BITS'(cmd_q.dx);
        sq_y_d  = plp_pkg::SQ_BITS'(cmd_q.dy) * plp_pkg::SQ_BITS'(cmd_q.dy);
        state_d = plp_pkg::B_SUM;
      end
      plp_pkg::B_SUM: begin
        rad_d   = plp_pkg::RAD_BITS'(sq_x_q) + plp_pkg::RAD_BITS'(sq_y_q);
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = plp_pkg::CNT_BITS'(plp_pkg::ROOT_BITS - 1);
        state_d = plp_pkg::B_ROOT;
      end
      plp_pkg::B_ROOT: begin
        // One root bit per cycle from the top pair of the radicand.
        if (shifted >= trial) begin
          rem_d  = plp_pkg::REM_BITS'(shifted - trial);
          root_d = {root_q[plp_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_d  = plp_pkg::REM_BITS'(shifted);
          root_d = {root_q[plp_pkg::ROOT_BITS-2:0], 1'b0};
        end
        rad_d = rad_q << 2;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = plp_pkg::B_ACCUM;
        end
      end
      plp_pkg::B_ACCUM: begin
        if (acc_sum > plp_pkg::ACC_BITS'(plp_pkg::TOTAL_MAX)) begin
          total_d = plp_pkg::TOTAL_MAX;
        end else begin
          total_d = acc_sum[plp_pkg::TOTAL_BITS-1:0];
        end
        state_d = cmd_q.last ? plp_pkg::B_EMIT : plp_pkg::B_IDLE;
      end
      plp_pkg::B_EMIT: begin
        // Hold until the result register is free, then clear the path.
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.path_length = total_q;
          out_d.saturated   = (total_q == plp_pkg::TOTAL_MAX);
          total_d           = '0;
          state_d           = plp_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = plp_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plp_pkg::B_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    cmd_q  <= cmd_d;
    sq_x_q <= sq_x_d;
    sq_y_q <= sq_y_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
  end

endmodule
`default_nettype wire

// ----- design/polyline_path_length_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_path_length_unit: streaming Euclidean path length
// Sums floor(sqrt(dx^2 + dy^2)) over the points of a path, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one request per point (x, y in Q15.8, last_point flag),
//   taken at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel: one request per path, on its last point, holding the
//   saturating total length (8 fraction bits) and a saturated flag; it is
//   taken at an edge with out_valid_o high and out_stall_i low.
// Timing:
//   The front end takes a point and queues it (two entries).
//   The back end handles a point that closes a segment in the steps pop,
//   square, sum, 25 square root iterations (one root bit per cycle) and
//   accumulate; a first point is only popped and accumulated.
//   A last point adds an emit step that loads the result register.
//   The back end takes no new point from the queue before it is done
//   with the last one.
// Stall and reset:
//   A stalled result holds in its register; the back end waits only when
//   the next path finishes before it is taken, and the queue then fills and
//   raises in_stall_o. Reset clears the queue, the path state and the total.
// ----------------------------------------------------------------------------
module polyline_path_length_unit (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  plp_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output plp_pkg::out_req_t  out_req_o
);

  plp_pkg::queue_status_t  q_stat;
  plp_pkg::seg_cmd_t       push_cmd;
  plp_pkg::seg_cmd_t       pop_cmd;
  logic                    push;
  logic                    pop;

  // Front end: difference magnitudes against the previous point.
  plp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Decouple intake from the multi-cycle length computation.
  plp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .stat_o     (q_stat)
  );

  // Back end: square, root, accumulate, emit.
  plp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_cmd_i   (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

`ifndef SYNTHESIS
  a_queue_status_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_sat_means_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.saturated |-> (out_req_o.path_length == plp_pkg::TOTAL_MAX))
    else $error("saturated flag without a maximal total");

  a_max_means_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.path_length == plp_pkg::TOTAL_MAX) |-> out_req_o.saturated)
    else $error("maximal total without saturated flag");

  a_pop_only_when_filled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !$past(q_stat.empty))
    else $error("back end popped an empty queue");
`endif

endmodule
`default_nettype wire
